/* design/stt_pkg.sv */
// shared types, codes and character helpers for the source text tokenizer
`default_nettype none

package stt_pkg;

  typedef logic [4:0]  kind_t;
  typedef logic [1:0]  err_t;
  typedef logic [15:0] line_t;
  typedef logic [19:0] offset_t;
  typedef logic [9:0]  length_t;

  localparam int unsigned MAX_RECS = 3;

  localparam kind_t KIND_DOT     = 5'd6;
  localparam kind_t KIND_PLUS    = 5'd10;
  localparam kind_t KIND_MINUS   = 5'd13;
  localparam kind_t KIND_STAR    = 5'd16;
  localparam kind_t KIND_SLASH   = 5'd19;
  localparam kind_t KIND_ASSIGN  = 5'd22;
  localparam kind_t KIND_EQUALS  = 5'd23;
  localparam kind_t KIND_IDENT   = 5'd24;
  localparam kind_t KIND_TYPE    = 5'd25;
  localparam kind_t KIND_INT     = 5'd26;
  localparam kind_t KIND_DECIMAL = 5'd27;
  localparam kind_t KIND_STRING  = 5'd28;
  localparam kind_t KIND_CHAR    = 5'd29;
  localparam kind_t KIND_NONE    = 5'd0;

  localparam err_t ERR_NONE         = 2'd0;
  localparam err_t ERR_UNEXPECTED   = 2'd1;
  localparam err_t ERR_UNTERMINATED = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_S = 8'h73;

  typedef struct packed {
    kind_t   kind;
    err_t    err;
    line_t   line;
    offset_t start;
    length_t len;
    logic    last;
  } rec_t;

  typedef struct packed {
    rec_t [MAX_RECS-1:0] rec;
    logic [1:0]          cnt;
  } batch_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || c == CH_UNDER ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // bit 5 flags a hit, low bits carry the kind
  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] r;
    r = '0;
    unique case (c)
      CH_LPAREN: r = {1'b1, 5'd0};
      CH_RPAREN: r = {1'b1, 5'd1};
      CH_LBRACK: r = {1'b1, 5'd2};
      CH_RBRACK: r = {1'b1, 5'd3};
      CH_LBRACE: r = {1'b1, 5'd4};
      CH_RBRACE: r = {1'b1, 5'd5};
      CH_DOT:    r = {1'b1, KIND_DOT};
      CH_COMMA:  r = {1'b1, 5'd7};
      CH_COLON:  r = {1'b1, 5'd8};
      CH_SEMI:   r = {1'b1, 5'd9};
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
  endfunction

  function automatic kind_t op_base(input logic [7:0] c);
    kind_t k;
    priority if (c == CH_PLUS) k = KIND_PLUS;
    else if (c == CH_MINUS) k = KIND_MINUS;
    else if (c == CH_STAR) k = KIND_STAR;
    else k = KIND_SLASH;
    return k;
  endfunction

  function automatic logic [7:0] kw_int_char(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0:    r = 8'h69;
      2'd1:    r = 8'h6e;
      2'd2:    r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_str_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h73;
      3'd1:    r = 8'h74;
      3'd2:    r = 8'h72;
      3'd3:    r = 8'h69;
      3'd4:    r = 8'h6e;
      3'd5:    r = 8'h67;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/source_text_tokenizer.sv */
// top level of the source text tokenizer: input register, scanner and record queue
//
// usage: one source byte per slave word, tdata[7:0] the character, tlast marks end
// of text (the byte is then ignored, any pending token is flushed and the line and
// offset counters restart). each master word is one token record: tuser carries
// kind and error code, tdata carries line, start offset and length, tlast marks the
// final record caused by one input word.
// path: a word is registered at acceptance, scanned from that register once the queue
// has room, and its records are written into the queue that feeds the master side.
// throughput: one input word per cycle while each word yields at most one record
// and the master side is ready; a word yielding two or three records is drained one
// record at a time through the single record read port of the four-entry output queue.
// a word is scanned only when the queue has room for all of its records, so a
// stalled master side fills the queue and then drops s_axis_tready_o; nothing is
// lost. reset returns the scanner to idle at line 1, offset 0, empties the queue.
`default_nettype none

module source_text_tokenizer #(
  parameter int unsigned POSITION_BITS = 20,
  parameter int unsigned LINE_BITS     = 16,
  parameter int unsigned LENGTH_BITS   = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // char_code
  input  wire logic        s_axis_tlast_i,   // end_of_text
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // line_number, start_offset, token_length, zeros
  output logic [6:0]       m_axis_tuser_o,   // token_kind, error_code
  output logic             m_axis_tlast_o    // last_of_run
);

  logic            in_vq, in_vd;
  logic [7:0]      char_q;
  logic            eot_q;
  logic            accept;
  logic            fire;
  logic [2:0]      free;
  stt_pkg::batch_t batch;
  stt_pkg::rec_t   rec;

  assign fire            = in_vq && ({1'b0, batch.cnt} <= free);
  assign s_axis_tready_o = !in_vq || fire;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_vd           = accept ? 1'b1 : (fire ? 1'b0 : in_vq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else begin
      in_vq <= in_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= s_axis_tdata_i;
      eot_q  <= s_axis_tlast_i;
    end
  end

  stt_scan #(
    .POSITION_BITS (POSITION_BITS),
    .LINE_BITS     (LINE_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (fire),
    .char_i  (char_q),
    .eot_i   (eot_q),
    .batch_o (batch)
  );

  stt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .batch_i (batch),
    .pop_i   (m_axis_tready_i),
    .rec_o   (rec),
    .valid_o (m_axis_tvalid_o),
    .free_o  (free)
  );

  assign m_axis_tdata_o = {2'b00, rec.len, rec.start, rec.line};
  assign m_axis_tuser_o = {rec.err, rec.kind};
  assign m_axis_tlast_o = rec.last;

  // a held word that cannot be scanned stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vq && !fire |=> in_vq && $stable(char_q) && $stable(eot_q))
    else $error("held input word lost or changed");

  // records pushed by a scan step are visible on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && batch.cnt != 2'd0 |=> m_axis_tvalid_o)
    else $error("records of a scan step not presented");

  // the queue never reports more room than it has
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free <= 3'd4 && (m_axis_tvalid_o == (free != 3'd4)))
    else $error("record queue occupancy inconsistent");

endmodule

`default_nettype wire

/* design/stt_scan.sv */
// scanner state and one-character step producing up to three token records
`default_nettype none

module stt_scan #(
  parameter int unsigned POSITION_BITS = 20,
  parameter int unsigned LINE_BITS     = 16,
  parameter int unsigned LENGTH_BITS   = 10
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     char_i,
  input  wire logic           eot_i,
  output stt_pkg::batch_t     batch_o
);

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_INT, MODE_INT_DOT, MODE_DECIMAL, MODE_OP,
    MODE_ASSIGN, MODE_STRING, MODE_BSLASH, MODE_LINE, MODE_BLOCK, MODE_BLOCK_BS
  } mode_e;

  localparam logic [1:0] KW_NONE = 2'd0;
  localparam logic [1:0] KW_INT  = 2'd1;
  localparam logic [1:0] KW_STR  = 2'd2;

  localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
  localparam logic [LINE_BITS-1:0]     LINE_MAX = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX  = '1;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [LINE_BITS-1:0]     lcnt_t;
  typedef logic [LENGTH_BITS-1:0]   blen_t;

  mode_e      mode_q, mode_d;
  logic [7:0] held_q, held_d;
  pos_t       spos_q, spos_d;
  lcnt_t      sline_q, sline_d;
  blen_t      blen_q, blen_d;
  logic [1:0] kwp_q, kwp_d;
  lcnt_t      line_q, line_d;
  pos_t       pos_q, pos_d;
  logic       halted_q, halted_d;

  stt_pkg::batch_t batch;
  logic [1:0]      idx;
  logic            again;
  logic [5:0]      pk;
  pos_t            prev_pos;
  logic            is_type;

  function automatic pos_t inc_pos(input pos_t v);
    return (v == POS_MAX) ? v : v + pos_t'(1);
  endfunction

  function automatic lcnt_t inc_line(input lcnt_t v);
    return (v == LINE_MAX) ? v : v + lcnt_t'(1);
  endfunction

  function automatic blen_t inc_len(input blen_t v);
    return (v == LEN_MAX) ? v : v + blen_t'(1);
  endfunction

  function automatic stt_pkg::rec_t mk_rec(input stt_pkg::kind_t kind, input stt_pkg::err_t err,
                                           input lcnt_t line, input pos_t start,
                                           input blen_t len);
    stt_pkg::rec_t r;
    r.kind  = kind;
    r.err   = err;
    r.line  = stt_pkg::line_t'(line);
    r.start = stt_pkg::offset_t'(start);
    r.len   = stt_pkg::length_t'(len);
    r.last  = 1'b0;
    return r;
  endfunction

  always_comb begin
    batch    = '0;
    idx      = 2'd0;
    again    = 1'b0;
    mode_d   = mode_q;
    held_d   = held_q;
    spos_d   = spos_q;
    sline_d  = sline_q;
    blen_d   = blen_q;
    kwp_d    = kwp_q;
    line_d   = line_q;
    pos_d    = pos_q;
    halted_d = halted_q;
    pk       = stt_pkg::punct_kind(char_i);
    prev_pos = (pos_q != '0) ? pos_q - pos_t'(1) : '0;
    is_type  = (kwp_q == KW_INT && blen_q == blen_t'(3)) ||
               (kwp_q == KW_STR && blen_q == blen_t'(6));

    if (eot_i) begin
      if (!halted_q) begin
        unique case (mode_q)
          MODE_IDENT: begin
            batch.rec[idx] = mk_rec(is_type ? stt_pkg::KIND_TYPE : stt_pkg::KIND_IDENT,
                                    stt_pkg::ERR_NONE, sline_q, spos_q, blen_q);
            idx = idx + 2'd1;
          end
          MODE_INT: begin
            batch.rec[idx] = mk_rec(stt_pkg::KIND_INT, stt_pkg::ERR_NONE, sline_q, spos_q,
                                    blen_q);
            idx = idx + 2'd1;
          end
          MODE_INT_DOT: begin
            batch.rec[idx] = mk_rec(stt_pkg::KIND_INT, stt_pkg::ERR_NONE, sline_q, spos_q,
                                    blen_q);
            idx = idx + 2'd1;
            batch.rec[idx] = mk_rec(stt_pkg::KIND_DOT, stt_pkg::ERR_NONE, sline_q, prev_pos,
                                    blen_t'(1));
            idx = idx + 2'd1;
          end
          MODE_DECIMAL: begin
            batch.rec[idx] = mk_rec(stt_pkg::KIND_DECIMAL, stt_pkg::ERR_NONE, sline_q, spos_q,
                                    blen_q);
            idx = idx + 2'd1;
          end
          MODE_OP: begin
            batch.rec[idx] = mk_rec(stt_pkg::op_base(held_q), stt_pkg::ERR_NONE, sline_q,
                                    spos_q, blen_t'(1));
            idx = idx + 2'd1;
          end
          MODE_ASSIGN: begin
            batch.rec[idx] = mk_rec(stt_pkg::KIND_ASSIGN, stt_pkg::ERR_NONE, sline_q, spos_q,
                                    blen_t'(1));
            idx = idx + 2'd1;
          end
          MODE_STRING: begin
            batch.rec[idx] = mk_rec(stt_pkg::KIND_NONE, stt_pkg::ERR_UNTERMINATED, sline_q,
                                    spos_q, blen_q);
            idx = idx + 2'd1;
          end
          default: begin
          end
        endcase
      end
      mode_d   = MODE_IDLE;
      held_d   = '0;
      spos_d   = '0;
      sline_d  = lcnt_t'(1);
      blen_d   = '0;
      kwp_d    = KW_NONE;
      line_d   = lcnt_t'(1);
      pos_d    = '0;
      halted_d = 1'b0;
    end else if (!halted_q) begin
      unique case (mode_q)
        MODE_IDENT: begin
          if (stt_pkg::is_alpha(char_i) || stt_pkg::is_digit(char_i)) begin
            if (kwp_q == KW_INT && !(blen_q < blen_t'(3) &&
                stt_pkg::kw_int_char(blen_q[1:0]) == char_i)) begin
              kwp_d = KW_NONE;
            end
            if (kwp_q == KW_STR && !(blen_q < blen_t'(6) &&
                stt_pkg::kw_str_char(blen_q[2:0]) == char_i)) begin
              kwp_d = KW_NONE;
            end
            blen_d = inc_len(blen_q);
          end else begin
            batch.rec[idx] = mk_rec(is_type ? stt_pkg::KIND_TYPE : stt_pkg::KIND_IDENT,
                                    stt_pkg::ERR_NONE, sline_q, spos_q, blen_q);
            idx   = idx + 2'd1;
            again = 1'b1;
          end
        end
        MODE_INT: begin
          if (stt_pkg::is_digit(char_i)) begin
            blen_d = inc_len(blen_q);
          end else if (char_i == stt_pkg::CH_DOT) begin
            mode_d = MODE_INT_DOT;
          end else begin
            batch.rec[idx] = mk_rec(stt_pkg::KIND_INT, stt_pkg::ERR_NONE, sline_q, spos_q,
                                    blen_q);
            idx   = idx + 2'd1;
            again = 1'b1;
          end
        end
        MODE_INT_DOT: begin
          if (stt_pkg::is_digit(char_i)) begin
            mode_d = MODE_DECIMAL;
            blen_d = inc_len(inc_len(blen_q));
          end else begin
            batch.rec[idx] = mk_rec(stt_pkg::KIND_INT, stt_pkg::ERR_NONE, sline_q, spos_q,
                                    blen_q);
            idx = idx + 2'd1;
            batch.rec[idx] = mk_rec(stt_pkg::KIND_DOT, stt_pkg::ERR_NONE, sline_q, prev_pos,
                                    blen_t'(1));
            idx   = idx + 2'd1;
            again = 1'b1;
          end
        end
        MODE_DECIMAL: begin
          if (stt_pkg::is_digit(char_i)) begin
            blen_d = inc_len(blen_q);
          end else begin
            batch.rec[idx] = mk_rec(stt_pkg::KIND_DECIMAL, stt_pkg::ERR_NONE, sline_q, spos_q,
                                    blen_q);
            idx   = idx + 2'd1;
            again = 1'b1;
          end
        end
        MODE_OP: begin
          if (char_i == stt_pkg::CH_EQ || char_i == held_q) begin
            batch.rec[idx] = mk_rec(stt_pkg::op_base(held_q) +
                                    ((char_i == stt_pkg::CH_EQ) ? 5'd2 : 5'd1),
                                    stt_pkg::ERR_NONE, sline_q, spos_q, blen_t'(2));
            idx    = idx + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            batch.rec[idx] = mk_rec(stt_pkg::op_base(held_q), stt_pkg::ERR_NONE, sline_q,
                                    spos_q, blen_t'(1));
            idx   = idx + 2'd1;
            again = 1'b1;
          end
        end
        MODE_ASSIGN: begin
          if (char_i == stt_pkg::CH_EQ) begin
            batch.rec[idx] = mk_rec(stt_pkg::KIND_EQUALS, stt_pkg::ERR_NONE, sline_q, spos_q,
                                    blen_t'(2));
            idx    = idx + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            batch.rec[idx] = mk_rec(stt_pkg::KIND_ASSIGN, stt_pkg::ERR_NONE, sline_q, spos_q,
                                    blen_t'(1));
            idx   = idx + 2'd1;
            again = 1'b1;
          end
        end
        MODE_STRING: begin
          if (char_i == held_q) begin
            batch.rec[idx] = mk_rec((blen_q == blen_t'(1)) ? stt_pkg::KIND_CHAR
                                                            : stt_pkg::KIND_STRING,
                                    stt_pkg::ERR_NONE, sline_q, spos_q, blen_q);
            idx    = idx + 2'd1;
            mode_d = MODE_IDLE;
          end else if (char_i == stt_pkg::CH_NL || char_i == stt_pkg::CH_NUL) begin
            batch.rec[idx] = mk_rec(stt_pkg::KIND_NONE, stt_pkg::ERR_UNTERMINATED, sline_q,
                                    spos_q, blen_q);
            idx      = idx + 2'd1;
            mode_d   = MODE_IDLE;
            halted_d = 1'b1;
          end else begin
            blen_d = inc_len(blen_q);
          end
        end
        MODE_BSLASH: begin
          priority if (char_i == stt_pkg::CH_LPAREN) begin
            mode_d = MODE_BLOCK;
          end else if (char_i == stt_pkg::CH_NL) begin
            line_d = inc_line(line_q);
            mode_d = MODE_IDLE;
          end else begin
            mode_d = MODE_LINE;
          end
        end
        MODE_LINE: begin
          if (char_i == stt_pkg::CH_NL) begin
            line_d = inc_line(line_q);
            mode_d = MODE_IDLE;
          end
        end
        MODE_BLOCK: begin
          priority if (char_i == stt_pkg::CH_BSLASH) begin
            mode_d = MODE_BLOCK_BS;
          end else if (char_i == stt_pkg::CH_NL) begin
            line_d = inc_line(line_q);
          end
        end
        MODE_BLOCK_BS: begin
          priority if (char_i == stt_pkg::CH_RPAREN) begin
            mode_d = MODE_IDLE;
          end else if (char_i == stt_pkg::CH_BSLASH) begin
            mode_d = MODE_BLOCK_BS;
          end else begin
            if (char_i == stt_pkg::CH_NL) begin
              line_d = inc_line(line_q);
            end
            mode_d = MODE_BLOCK;
          end
        end
        default: begin
          again = 1'b1;
        end
      endcase

      // fresh scan of the current character from idle
      if (again) begin
        mode_d = MODE_IDLE;
        priority if (stt_pkg::is_alpha(char_i)) begin
          mode_d  = MODE_IDENT;
          spos_d  = pos_q;
          sline_d = line_q;
          blen_d  = blen_t'(1);
          kwp_d   = (char_i == stt_pkg::CH_I) ? KW_INT :
                    (char_i == stt_pkg::CH_S) ? KW_STR : KW_NONE;
        end else if (stt_pkg::is_digit(char_i)) begin
          mode_d  = MODE_INT;
          spos_d  = pos_q;
          sline_d = line_q;
          blen_d  = blen_t'(1);
        end else if (pk[5]) begin
          batch.rec[idx] = mk_rec(pk[4:0], stt_pkg::ERR_NONE, line_q, pos_q, blen_t'(1));
          idx = idx + 2'd1;
        end else if (char_i == stt_pkg::CH_BSLASH) begin
          mode_d = MODE_BSLASH;
        end else if (stt_pkg::is_op(char_i)) begin
          mode_d  = MODE_OP;
          spos_d  = pos_q;
          sline_d = line_q;
          blen_d  = blen_t'(1);
          held_d  = char_i;
        end else if (char_i == stt_pkg::CH_EQ) begin
          mode_d  = MODE_ASSIGN;
          spos_d  = pos_q;
          sline_d = line_q;
          blen_d  = blen_t'(1);
        end else if (char_i == stt_pkg::CH_DQUOTE || char_i == stt_pkg::CH_SQUOTE) begin
          mode_d  = MODE_STRING;
          spos_d  = pos_q;
          sline_d = line_q;
          blen_d  = '0;
          held_d  = char_i;
        end else if (char_i == stt_pkg::CH_SPACE || char_i == stt_pkg::CH_TAB) begin
        end else if (char_i == stt_pkg::CH_NL) begin
          line_d = inc_line(line_q);
        end else begin
          batch.rec[idx] = mk_rec(stt_pkg::KIND_NONE, stt_pkg::ERR_UNEXPECTED, line_q, pos_q,
                                  blen_t'(1));
          idx      = idx + 2'd1;
          halted_d = 1'b1;
        end
      end
      pos_d = inc_pos(pos_q);
    end

    if (idx != 2'd0) begin
      batch.rec[idx - 2'd1].last = 1'b1;
    end
    batch.cnt = idx;
  end

  assign batch_o = batch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      held_q   <= '0;
      spos_q   <= '0;
      sline_q  <= lcnt_t'(1);
      blen_q   <= '0;
      kwp_q    <= KW_NONE;
      line_q   <= lcnt_t'(1);
      pos_q    <= '0;
      halted_q <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      held_q   <= held_d;
      spos_q   <= spos_d;
      sline_q  <= sline_d;
      blen_q   <= blen_d;
      kwp_q    <= kwp_d;
      line_q   <= line_d;
      pos_q    <= pos_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

/* design/stt_fifo.sv */
// four-entry record queue taking up to three records per cycle and giving one
`default_nettype none

module stt_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  stt_pkg::batch_t      batch_i,
  input  wire logic            pop_i,
  output stt_pkg::rec_t        rec_o,
  output logic                 valid_o,
  output logic [2:0]           free_o
);

  localparam int unsigned DEPTH = 4;

  stt_pkg::rec_t mem_q [DEPTH];
  logic [1:0]    wr_q, wr_d;
  logic [1:0]    rd_q, rd_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [2:0]    push_n;
  logic          pop;

  assign push_n  = push_i ? {1'b0, batch_i.cnt} : 3'd0;
  assign valid_o = cnt_q != 3'd0;
  assign pop     = pop_i && valid_o;
  assign rec_o   = mem_q[rd_q];
  assign free_o  = 3'(DEPTH) - cnt_q;

  always_comb begin
    wr_d  = wr_q + push_n[1:0];
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + push_n - {2'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < stt_pkg::MAX_RECS; k++) begin
      if (push_i && 2'(k) < batch_i.cnt) begin
        mem_q[wr_q + 2'(k)] <= batch_i.rec[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* verif/tb_source_text_tokenizer.sv */
// self-checking testbench for the source text tokenizer: directed and random text in, token records checked
`timescale 1ns / 1ps

module tb_source_text_tokenizer;
  import stt_pkg::*;

  localparam int unsigned RANDOM_WORDS = 445;
  localparam int unsigned LONG_WORD_LEN = 1030;
  localparam int unsigned MAX_GAP = 14;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned HOLD_AT_A = 30;
  localparam int unsigned HOLD_AT_B = 120;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned OP_DOUBLED = 1;
  localparam int unsigned OP_WITH_EQ = 2;

  localparam string PUNCT_SET = "()[]{}.,:;";
  localparam string OP_SET = "+-*/";
  localparam string SEP_SET = " \t\n";
  localparam string INT_WORD = "int";
  localparam string STR_WORD = "string";

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_INT, SCAN_INT_DOT, SCAN_FRACTION, SCAN_OP, SCAN_ASSIGN,
    SCAN_QUOTED, SCAN_BACKSLASH, SCAN_LINE_NOTE, SCAN_BLOCK_NOTE, SCAN_BLOCK_BS
  } scan_e;

  typedef enum logic [1:0] {KW_NONE, KW_INT, KW_STRING} kw_e;

  typedef struct {
    logic [7:0] code;
    logic       eot;
  } src_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic [6:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  source_text_tokenizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  string near_words[10] = '{"int", "string", "in", "strin", "ints", "strings", "i", "s",
                            "it", "sting"};

  src_word_t src_words[$];
  rec_t      due_tokens[$];
  rec_t      step_recs[$];

  // scanner copy
  scan_e      scan_mode = SCAN_IDLE;
  logic [7:0] held_ch = '0;
  offset_t    tok_start = '0;
  line_t      tok_line = 16'd1;
  length_t    tok_len = '0;
  kw_e        kw_hint = KW_NONE;
  line_t      line_cnt = 16'd1;
  offset_t    pos_cnt = '0;
  logic       halted = 1'b0;

  int unsigned total_words;
  int unsigned words_in = 0;
  int unsigned texts_in = 0;
  int unsigned recs_checked = 0;
  int unsigned errs_seen = 0;
  int unsigned mismatches = 0;
  logic [31:0] kinds_seen = '0;
  int unsigned stuck_cycles = 0;

  src_word_t   next_word;
  int unsigned src_gap = 0;
  logic        src_lazy = 1'b1;
  int unsigned snk_gap = 0;
  int unsigned hold_left = 0;
  int unsigned recs_taken = 0;
  int unsigned gap_draw;
  logic        snk_lazy = 1'b1;
  logic        snk_took;
  rec_t        want;

  function automatic int unsigned draw_gap(input logic lazy);
    return lazy ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  function automatic logic letter_ch(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
           c == CH_UNDER;
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic int punct_index(input logic [7:0] c);
    for (int i = 0; i < PUNCT_SET.len(); i++) begin
      if (PUNCT_SET[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic kind_t op_kind(input logic [7:0] c);
    case (c)
      CH_PLUS:  return KIND_PLUS;
      CH_MINUS: return KIND_MINUS;
      CH_STAR:  return KIND_STAR;
      default:  return KIND_SLASH;
    endcase
  endfunction

  function automatic length_t len_up(input length_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic add_rec(input kind_t k, input err_t e, input line_t ln, input offset_t st,
                         input length_t n);
    rec_t r;
    r.kind = k;
    r.err = e;
    r.line = ln;
    r.start = st;
    r.len = n;
    r.last = 1'b0;
    step_recs.push_back(r);
  endtask

  task automatic bump_line();
    if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
  endtask

  task automatic open_token(input scan_e m, input offset_t at, input length_t n);
    scan_mode = m;
    tok_start = at;
    tok_line = line_cnt;
    tok_len = n;
  endtask

  task automatic close_ident();
    logic is_kw;
    is_kw = (kw_hint == KW_INT && tok_len == INT_WORD.len()) ||
            (kw_hint == KW_STRING && tok_len == STR_WORD.len());
    add_rec(is_kw ? KIND_TYPE : KIND_IDENT, ERR_NONE, tok_line, tok_start, tok_len);
  endtask

  task automatic close_int_dot(input offset_t dot_at);
    add_rec(KIND_INT, ERR_NONE, tok_line, tok_start, tok_len);
    add_rec(KIND_DOT, ERR_NONE, tok_line, dot_at, 1);
  endtask

  task automatic clear_scanner();
    scan_mode = SCAN_IDLE;
    held_ch = '0;
    tok_start = '0;
    tok_line = 16'd1;
    tok_len = '0;
    kw_hint = KW_NONE;
    line_cnt = 16'd1;
    pos_cnt = '0;
    halted = 1'b0;
  endtask

  task automatic scan_fresh(input logic [7:0] c, input offset_t at);
    int pk;
    pk = punct_index(c);
    scan_mode = SCAN_IDLE;
    if (letter_ch(c)) begin
      open_token(SCAN_IDENT, at, 1);
      kw_hint = (c == CH_I) ? KW_INT : (c == CH_S) ? KW_STRING : KW_NONE;
    end else if (digit_ch(c)) begin
      open_token(SCAN_INT, at, 1);
    end else if (pk >= 0) begin
      add_rec(kind_t'(pk), ERR_NONE, line_cnt, at, 1);
    end else if (c == CH_BSLASH) begin
      scan_mode = SCAN_BACKSLASH;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      open_token(SCAN_OP, at, 1);
      held_ch = c;
    end else if (c == CH_EQ) begin
      open_token(SCAN_ASSIGN, at, 1);
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      open_token(SCAN_QUOTED, at, 0);
      held_ch = c;
    end else if (c == CH_NL) begin
      bump_line();
    end else if (c != CH_SPACE && c != CH_TAB) begin
      add_rec(KIND_NONE, ERR_UNEXPECTED, line_cnt, at, 1);
      halted = 1'b1;
    end
  endtask

  task automatic flush_token();
    offset_t prev;
    prev = (pos_cnt != 0) ? pos_cnt - 1'b1 : '0;
    case (scan_mode)
      SCAN_IDENT:    close_ident();
      SCAN_INT:      add_rec(KIND_INT, ERR_NONE, tok_line, tok_start, tok_len);
      SCAN_INT_DOT:  close_int_dot(prev);
      SCAN_FRACTION: add_rec(KIND_DECIMAL, ERR_NONE, tok_line, tok_start, tok_len);
      SCAN_OP:       add_rec(op_kind(held_ch), ERR_NONE, tok_line, tok_start, 1);
      SCAN_ASSIGN:   add_rec(KIND_ASSIGN, ERR_NONE, tok_line, tok_start, 1);
      SCAN_QUOTED:   add_rec(KIND_NONE, ERR_UNTERMINATED, tok_line, tok_start, tok_len);
      default: ;
    endcase
  endtask

  // works out the records one source word causes and queues them as due
  task automatic scan_char(input logic [7:0] c, input logic eot);
    offset_t here;
    logic    rescan;
    here = pos_cnt;
    rescan = 1'b0;
    step_recs.delete();
    if (eot) begin
      if (!halted) flush_token();
      clear_scanner();
    end else if (!halted) begin
      case (scan_mode)
        SCAN_IDENT: begin
          if (letter_ch(c) || digit_ch(c)) begin
            if (kw_hint == KW_INT && !(tok_len < INT_WORD.len() && INT_WORD[tok_len] == c))
              kw_hint = KW_NONE;
            if (kw_hint == KW_STRING && !(tok_len < STR_WORD.len() && STR_WORD[tok_len] == c))
              kw_hint = KW_NONE;
            tok_len = len_up(tok_len);
          end else begin
            close_ident();
            rescan = 1'b1;
          end
        end
        SCAN_INT: begin
          if (digit_ch(c)) tok_len = len_up(tok_len);
          else if (c == CH_DOT) scan_mode = SCAN_INT_DOT;
          else begin
            add_rec(KIND_INT, ERR_NONE, tok_line, tok_start, tok_len);
            rescan = 1'b1;
          end
        end
        SCAN_INT_DOT: begin
          if (digit_ch(c)) begin
            scan_mode = SCAN_FRACTION;
            tok_len = len_up(len_up(tok_len));
          end else begin
            close_int_dot((here != 0) ? here - 1'b1 : '0);
            rescan = 1'b1;
          end
        end
        SCAN_FRACTION: begin
          if (digit_ch(c)) tok_len = len_up(tok_len);
          else begin
            add_rec(KIND_DECIMAL, ERR_NONE, tok_line, tok_start, tok_len);
            rescan = 1'b1;
          end
        end
        SCAN_OP: begin
          if (c == CH_EQ || c == held_ch) begin
            add_rec(op_kind(held_ch) + (c == CH_EQ ? OP_WITH_EQ : OP_DOUBLED), ERR_NONE,
                    tok_line, tok_start, 2);
            scan_mode = SCAN_IDLE;
          end else begin
            add_rec(op_kind(held_ch), ERR_NONE, tok_line, tok_start, 1);
            rescan = 1'b1;
          end
        end
        SCAN_ASSIGN: begin
          if (c == CH_EQ) begin
            add_rec(KIND_EQUALS, ERR_NONE, tok_line, tok_start, 2);
            scan_mode = SCAN_IDLE;
          end else begin
            add_rec(KIND_ASSIGN, ERR_NONE, tok_line, tok_start, 1);
            rescan = 1'b1;
          end
        end
        SCAN_QUOTED: begin
          if (c == held_ch) begin
            add_rec(tok_len == 1 ? KIND_CHAR : KIND_STRING, ERR_NONE, tok_line, tok_start,
                    tok_len);
            scan_mode = SCAN_IDLE;
          end else if (c == CH_NL || c == CH_NUL) begin
            add_rec(KIND_NONE, ERR_UNTERMINATED, tok_line, tok_start, tok_len);
            scan_mode = SCAN_IDLE;
            halted = 1'b1;
          end else begin
            tok_len = len_up(tok_len);
          end
        end
        SCAN_BACKSLASH: begin
          if (c == CH_LPAREN) scan_mode = SCAN_BLOCK_NOTE;
          else if (c == CH_NL) begin
            bump_line();
            scan_mode = SCAN_IDLE;
          end else scan_mode = SCAN_LINE_NOTE;
        end
        SCAN_LINE_NOTE: begin
          if (c == CH_NL) begin
            bump_line();
            scan_mode = SCAN_IDLE;
          end
        end
        SCAN_BLOCK_NOTE: begin
          if (c == CH_BSLASH) scan_mode = SCAN_BLOCK_BS;
          else if (c == CH_NL) bump_line();
        end
        SCAN_BLOCK_BS: begin
          if (c == CH_RPAREN) scan_mode = SCAN_IDLE;
          else if (c != CH_BSLASH) begin
            if (c == CH_NL) bump_line();
            scan_mode = SCAN_BLOCK_NOTE;
          end
        end
        default: rescan = 1'b1;
      endcase
      if (rescan) scan_fresh(c, here);
      if (pos_cnt != '1) pos_cnt = pos_cnt + 1'b1;
    end
    if (step_recs.size() != 0) step_recs[step_recs.size() - 1].last = 1'b1;
    foreach (step_recs[i]) due_tokens.push_back(step_recs[i]);
  endtask

  task automatic push_char(input logic [7:0] c);
    src_word_t w;
    w.code = c;
    w.eot = 1'b0;
    src_words.push_back(w);
  endtask

  task automatic push_eot();
    src_word_t w;
    w.code = $urandom_range(0, 255);
    w.eot = 1'b1;
    src_words.push_back(w);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    case ($urandom_range(0, 2))
      0:       return CH_UPPER_A + $urandom_range(0, 25);
      1:       return CH_LOWER_A + $urandom_range(0, 25);
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] rand_alnum();
    return $urandom_range(0, 3) == 0 ? CH_ZERO + $urandom_range(0, 9) : rand_letter();
  endfunction

  task automatic add_digits(input int unsigned n);
    for (int i = 0; i < n; i++) push_char(CH_ZERO + $urandom_range(0, 9));
  endtask

  // one random source fragment, mostly well-formed tokens
  task automatic add_fragment();
    logic [7:0]  q;
    logic [7:0]  b;
    int unsigned n;
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        if ($urandom_range(0, 1) == 0) push_text(near_words[$urandom_range(0, 9)]);
        else begin
          push_char(rand_letter());
          n = $urandom_range(0, 7);
          for (int i = 0; i < n; i++) push_char(rand_alnum());
        end
      end
      3: add_digits($urandom_range(1, 5));
      4: begin
        add_digits($urandom_range(1, 3));
        push_char(CH_DOT);
        add_digits($urandom_range(1, 3));
        if ($urandom_range(0, 2) == 0) begin
          push_char(CH_DOT);
          add_digits(1);
        end
      end
      5: begin
        add_digits($urandom_range(1, 3));
        push_char(CH_DOT);
      end
      6: push_char(PUNCT_SET[$urandom_range(0, PUNCT_SET.len() - 1)]);
      7: begin
        q = OP_SET[$urandom_range(0, 3)];
        push_char(q);
        case ($urandom_range(0, 3))
          0: push_char(q);
          1: push_char(CH_EQ);
          2: push_char(OP_SET[$urandom_range(0, 3)]);
          default: ;
        endcase
      end
      8: begin
        push_char(CH_EQ);
        if ($urandom_range(0, 1) == 0) push_char(CH_EQ);
      end
      9: begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        push_char(q);
        n = $urandom_range(0, 1) ? 1 : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          do b = $urandom_range(1, 255); while (b == q || b == CH_NL);
          push_char(b);
        end
        case ($urandom_range(0, 11))
          0: begin
            push_char(CH_NL);
            push_eot();
          end
          1: begin
            push_char(CH_NUL);
            push_eot();
          end
          2: push_eot();
          default: push_char(q);
        endcase
      end
      10: begin
        push_char(CH_BSLASH);
        if ($urandom_range(0, 3) == 0) push_char(CH_NL);
        else begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            do b = $urandom_range(0, 255); while (b == CH_NL || (i == 0 && b == CH_LPAREN));
            push_char(b);
          end
          if ($urandom_range(0, 7) == 0) push_eot();
          else push_char(CH_NL);
        end
      end
      11: begin
        push_char(CH_BSLASH);
        push_char(CH_LPAREN);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 7))
            0: push_char(CH_NL);
            1: begin
              push_char(CH_BSLASH);
              push_char(CH_BSLASH);
              push_char(CH_LPAREN);
            end
            2: begin
              push_char(CH_BSLASH);
              push_char(CH_NL);
            end
            3: push_char(CH_RPAREN);
            default: begin
              do b = $urandom_range(0, 255); while (b == CH_BSLASH);
              push_char(b);
            end
          endcase
        end
        if ($urandom_range(0, 7) == 0) push_eot();
        else begin
          push_char(CH_BSLASH);
          push_char(CH_RPAREN);
        end
      end
      13: begin
        push_char($urandom_range(0, 255));
        push_eot();
      end
      14: push_eot();
      default: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) push_char(SEP_SET[$urandom_range(0, 2)]);
      end
    endcase
    if ($urandom_range(0, 1) == 0) push_char(SEP_SET[$urandom_range(0, 2)]);
  endtask

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s expected %0d got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // source side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
      s_axis_tlast_i <= 1'b0;
      src_gap <= 0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (src_gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (src_words.size() != 0) begin
        next_word = src_words.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= next_word.code;
        s_axis_tlast_i <= next_word.eot;
        src_gap <= draw_gap(src_lazy);
        if ($urandom_range(0, 39) == 0) src_lazy <= !src_lazy;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // record side, with two long hold-offs to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      snk_gap <= 0;
      hold_left <= 0;
      recs_taken <= 0;
    end else begin
      snk_took = m_axis_tvalid_o && m_axis_tready_i;
      if (snk_took) recs_taken <= recs_taken + 1;
      if (snk_took && (recs_taken == HOLD_AT_A || recs_taken == HOLD_AT_B)) begin
        hold_left <= HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (snk_took) begin
        gap_draw = draw_gap(snk_lazy);
        if ($urandom_range(0, 29) == 0) snk_lazy <= !snk_lazy;
        if (gap_draw == 0) m_axis_tready_i <= 1'b1;
        else begin
          m_axis_tready_i <= 1'b0;
          snk_gap <= gap_draw - 1;
        end
      end else if (snk_gap != 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // prediction on accepted words, checking on accepted records
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        scan_char(s_axis_tdata_i, s_axis_tlast_i);
        words_in++;
        if (s_axis_tlast_i) texts_in++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        recs_checked++;
        if (due_tokens.size() == 0) begin
          $error("token record with none due: tuser %h tdata %h", m_axis_tuser_o,
                 m_axis_tdata_o);
          mismatches++;
        end else begin
          want = due_tokens.pop_front();
          if (want.err != ERR_NONE) errs_seen++;
          else kinds_seen[want.kind] = 1'b1;
          compare_field("token_kind", want.kind, m_axis_tuser_o[4:0]);
          compare_field("error_code", want.err, m_axis_tuser_o[6:5]);
          compare_field("line_number", want.line, m_axis_tdata_o[15:0]);
          compare_field("start_offset", want.start, m_axis_tdata_o[35:16]);
          compare_field("token_length", want.len, m_axis_tdata_o[45:36]);
          compare_field("last_of_run", want.last, m_axis_tlast_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d records still due", STALL_LIMIT,
               due_tokens.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    clear_scanner();
    // keyword, decimal then dot, equals, char literal, top byte
    push_text("int 9.5.x=='q'");
    push_char(8'hff);
    push_eot();
    // newline inside a string
    push_text("\"a\n");
    push_eot();
    // integer, dot and punct from one word, then byte zero
    push_text("1.;");
    push_char(CH_NUL);
    push_eot();
    total_words = src_words.size() + RANDOM_WORDS;
    while (src_words.size() < total_words) add_fragment();
    // long identifier drives the length to saturation
    push_char(CH_S);
    for (int i = 1; i < LONG_WORD_LEN; i++) push_char(rand_alnum());
    push_eot();
    total_words = src_words.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_in != total_words) @(posedge clk_i);
    while (due_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d source words in %0d texts, %0d token records checked",
             words_in, texts_in, recs_checked);
    $display("%0d of 30 token kinds seen, %0d error records", $countones(kinds_seen),
             errs_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
